// File: rtl/njm_pkg.sv
// Shared types, constants and mapping functions for the controller-to-joystick mapper.
// No dependencies; the mapper top level refers to everything here by scoped name.

package njm_pkg;

  localparam int unsigned AxisW     = 10;
  localparam int unsigned HatW      = 10;
  localparam int unsigned NumButtons = 10;
  localparam int unsigned NumAxes   = 4;

  localparam logic [AxisW-1:0] AxisMid   = 10'd512;
  localparam logic [HatW-1:0]  HatCenter = 10'h3FF;

  // stick modes
  localparam logic [1:0] ModeAnalog   = 2'd0;
  localparam logic [1:0] ModeDigital  = 2'd1;
  localparam logic [1:0] ModeFpsLeft  = 2'd2;
  localparam logic [1:0] ModeFpsRight = 2'd3;

  // direction bits
  localparam int unsigned DirUp    = 0;
  localparam int unsigned DirDown  = 1;
  localparam int unsigned DirLeft  = 2;
  localparam int unsigned DirRight = 3;

  // button bits
  localparam int unsigned BtnA      = 0;
  localparam int unsigned BtnB      = 1;
  localparam int unsigned BtnX      = 2;
  localparam int unsigned BtnY      = 3;
  localparam int unsigned BtnLb     = 4;
  localparam int unsigned BtnRb     = 5;
  localparam int unsigned BtnLt     = 6;
  localparam int unsigned BtnRt     = 7;
  localparam int unsigned BtnSelect = 8;
  localparam int unsigned BtnStart  = 9;

  // register indexes
  localparam logic RegCenterX = 1'b0;
  localparam logic RegCenterY = 1'b1;

  typedef struct packed {
    logic       activate;
    logic       tilted_up;
    logic       side_tilted;
    logic       c_pressed;
    logic       c_released;
    logic       z_pressed;
    logic       z_released;
    logic [3:0] dir_pressed;
    logic [3:0] dir_released;
    logic [3:0] digital_dir;
    logic [7:0] stick_x;
    logic [7:0] stick_y;
  } poll_t;

  // 512 + 5 * (sample - center), optionally mirrored, clamped to 0..1023
  function automatic logic [AxisW-1:0] axis_value(input logic [7:0] sample,
                                                  input logic [7:0] center,
                                                  input logic       invert);
    logic signed [11:0] diff;
    logic signed [11:0] v;
    diff = $signed({4'b0000, sample}) - $signed({4'b0000, center});
    v    = 12'sd512 + (diff <<< 2) + diff;
    if (invert) begin
      v = 12'sd1023 - v;
    end
    if (v < 12'sd0) begin
      v = 12'sd0;
    end else if (v > 12'sd1023) begin
      v = 12'sd1023;
    end
    return v[AxisW-1:0];
  endfunction

  // eight hat positions, anything else is centered
  function automatic logic [HatW-1:0] hat_from_dirs(input logic [3:0] d);
    logic [HatW-1:0] h;
    case (d)
      4'b0001: h = 10'd0;
      4'b1001: h = 10'd45;
      4'b1000: h = 10'd90;
      4'b1010: h = 10'd135;
      4'b0010: h = 10'd180;
      4'b0110: h = 10'd225;
      4'b0100: h = 10'd270;
      4'b0101: h = 10'd315;
      default: h = HatCenter;
    endcase
    return h;
  endfunction

endpackage

// File: rtl/nunchuck_to_joystick_mapper_unit.sv
// Controller-to-joystick mapper top level: poll input register, mapping logic, report state.
// Depends on njm_pkg for types, constants and the axis and hat functions.

// Usage
//   Input channel (in_valid_i / in_stall_o): one controller poll per transaction,
//   fields as separate ports. A transaction is taken at a rising edge with
//   in_valid_i high and in_stall_o low.
//   Output channel (out_valid_o / out_stall_i): one full joystick report per poll.
//   The report registers double as the mapper state (axes, hat, buttons, mode,
//   active flag), so each report reflects every poll taken so far.
//   Configuration: APB-style, the X stick origin at byte address 0, the Y stick
//   origin at 4. Write only while no poll is in flight.
// Flow and throughput
//   A taken poll waits in the input register, then passes through the mapping
//   logic into the report state; a stalled report can hold it in between.
//   One poll per cycle sustained while reports are not stalled; the mapping is a
//   single short pass (subtract, times five, clamp) between the two registers.
// Reset
//   Reports read axes 512, hat centered (all ones), no buttons, analog mode,
//   inactive; centers go to 128. No transaction is pending after reset.
// Stall
//   While out_stall_i holds a report, the report state holds, the input
//   register keeps its poll, and in_stall_o rises once that register is full.

module nunchuck_to_joystick_mapper_unit (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // poll channel
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    activate_i,
  input  logic                    tilted_up_i,
  input  logic                    side_tilted_i,
  input  logic                    c_pressed_i,
  input  logic                    c_released_i,
  input  logic                    z_pressed_i,
  input  logic                    z_released_i,
  input  logic [3:0]              dir_pressed_i,
  input  logic [3:0]              dir_released_i,
  input  logic [3:0]              digital_dir_i,
  input  logic [7:0]              stick_x_i,
  input  logic [7:0]              stick_y_i,
  // report channel
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [9:0]              axis_x_o,
  output logic [9:0]              axis_y_o,
  output logic [9:0]              axis_z_o,
  output logic [9:0]              axis_zrot_o,
  output logic signed [9:0]       hat_angle_o,
  output logic [9:0]              button_mask_o,
  output logic [1:0]              mode_now_o,
  output logic                    active_now_o,
  // configuration
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [2:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [7:0] x_origin_q;
  logic [7:0] y_origin_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_origin_q <= 8'd128;
      y_origin_q <= 8'd128;
    end else if (cfg_wr) begin
      if (paddr[2] == njm_pkg::RegCenterX) begin
        x_origin_q <= pwdata[7:0];
      end else begin
        y_origin_q <= pwdata[7:0];
      end
    end
  end

  assign prdata = (paddr[2] == njm_pkg::RegCenterX) ? {24'd0, x_origin_q}
                                                    : {24'd0, y_origin_q};

  // ---------------------------------------------------------------------------
  // Handshake: input register feeding the report state
  // ---------------------------------------------------------------------------
  njm_pkg::poll_t poll_d;
  njm_pkg::poll_t poll_q;
  logic           s1_valid_q;
  logic           out_valid_q;
  logic           s1_adv;
  logic           in_take;

  // advance the held poll when the report slot is empty or being taken
  assign s1_adv     = s1_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = s1_valid_q & ~s1_adv;
  assign in_take    = in_valid_i & ~in_stall_o;

  assign poll_d = '{
    activate:     activate_i,
    tilted_up:    tilted_up_i,
    side_tilted:  side_tilted_i,
    c_pressed:    c_pressed_i,
    c_released:   c_released_i,
    z_pressed:    z_pressed_i,
    z_released:   z_released_i,
    dir_pressed:  dir_pressed_i,
    dir_released: dir_released_i,
    digital_dir:  digital_dir_i,
    stick_x:      stick_x_i,
    stick_y:      stick_y_i
  };

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      poll_q <= poll_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Report state and mapping
  // ---------------------------------------------------------------------------
  logic [1:0]                       mode_q, mode_d;
  logic                             active_q, active_d;
  logic [njm_pkg::AxisW-1:0]        axis_q [njm_pkg::NumAxes];
  logic [njm_pkg::AxisW-1:0]        axis_d [njm_pkg::NumAxes];
  logic [njm_pkg::HatW-1:0]         hat_q, hat_d;
  logic [njm_pkg::NumButtons-1:0]   held_q, held_d;
  logic [njm_pkg::NumButtons-1:0]   press_m, rel_m;
  logic [njm_pkg::AxisW-1:0]        ax_x_val, ax_y_val;

  assign ax_x_val = njm_pkg::axis_value(poll_q.stick_x, x_origin_q, 1'b0);
  assign ax_y_val = njm_pkg::axis_value(poll_q.stick_y, y_origin_q, 1'b1);

  always_comb begin
    mode_d   = mode_q;
    active_d = active_q;
    axis_d   = axis_q;
    hat_d    = hat_q;
    press_m  = '0;
    rel_m    = '0;
    held_d   = held_q;

    if (poll_q.activate) begin
      active_d = 1'b1;
      axis_d   = '{default: njm_pkg::AxisMid};
      hat_d    = njm_pkg::HatCenter;
      held_d   = '0;
    end else if (poll_q.tilted_up) begin
      // select mode: clear the report, C drops active, pick mode, right has the last word
      axis_d = '{default: njm_pkg::AxisMid};
      hat_d  = njm_pkg::HatCenter;
      held_d = '0;
      if (poll_q.c_pressed) begin
        active_d = 1'b0;
      end
      if (poll_q.dir_pressed[njm_pkg::DirRight]) begin
        mode_d = njm_pkg::ModeFpsRight;
      end else if (poll_q.dir_pressed[njm_pkg::DirLeft]) begin
        mode_d = njm_pkg::ModeFpsLeft;
      end else if (poll_q.dir_pressed[njm_pkg::DirDown]) begin
        mode_d = njm_pkg::ModeDigital;
      end else if (poll_q.dir_pressed[njm_pkg::DirUp]) begin
        mode_d = njm_pkg::ModeAnalog;
      end
    end else if (poll_q.side_tilted) begin
      press_m[njm_pkg::BtnStart]  = poll_q.z_pressed;
      rel_m[njm_pkg::BtnStart]    = poll_q.z_released;
      press_m[njm_pkg::BtnSelect] = poll_q.c_pressed;
      rel_m[njm_pkg::BtnSelect]   = poll_q.c_released;
      press_m[njm_pkg::BtnB]      = poll_q.dir_pressed[njm_pkg::DirDown];
      rel_m[njm_pkg::BtnB]        = poll_q.dir_released[njm_pkg::DirDown];
      press_m[njm_pkg::BtnA]      = poll_q.dir_pressed[njm_pkg::DirRight];
      rel_m[njm_pkg::BtnA]        = poll_q.dir_released[njm_pkg::DirRight];
      press_m[njm_pkg::BtnY]      = poll_q.dir_pressed[njm_pkg::DirLeft];
      rel_m[njm_pkg::BtnY]        = poll_q.dir_released[njm_pkg::DirLeft];
      press_m[njm_pkg::BtnX]      = poll_q.dir_pressed[njm_pkg::DirUp];
      rel_m[njm_pkg::BtnX]        = poll_q.dir_released[njm_pkg::DirUp];
      // press beats release
      held_d = (held_q & ~rel_m) | press_m;
    end else begin
      case (mode_q)
        njm_pkg::ModeFpsLeft: begin
          press_m[njm_pkg::BtnLt] = poll_q.z_pressed;
          rel_m[njm_pkg::BtnLt]   = poll_q.z_released;
          press_m[njm_pkg::BtnLb] = poll_q.c_pressed;
          rel_m[njm_pkg::BtnLb]   = poll_q.c_released;
          axis_d[0] = ax_x_val;
          axis_d[1] = ax_y_val;
        end
        njm_pkg::ModeFpsRight: begin
          press_m[njm_pkg::BtnRt] = poll_q.z_pressed;
          rel_m[njm_pkg::BtnRt]   = poll_q.z_released;
          press_m[njm_pkg::BtnRb] = poll_q.c_pressed;
          rel_m[njm_pkg::BtnRb]   = poll_q.c_released;
          axis_d[2] = ax_y_val;
          axis_d[3] = ax_x_val;
        end
        njm_pkg::ModeDigital: begin
          press_m[njm_pkg::BtnB] = poll_q.z_pressed;
          rel_m[njm_pkg::BtnB]   = poll_q.z_released;
          press_m[njm_pkg::BtnA] = poll_q.c_pressed;
          rel_m[njm_pkg::BtnA]   = poll_q.c_released;
          hat_d = njm_pkg::hat_from_dirs(poll_q.digital_dir);
        end
        default: begin
          press_m[njm_pkg::BtnB] = poll_q.z_pressed;
          rel_m[njm_pkg::BtnB]   = poll_q.z_released;
          press_m[njm_pkg::BtnA] = poll_q.c_pressed;
          rel_m[njm_pkg::BtnA]   = poll_q.c_released;
          axis_d[0] = ax_x_val;
          axis_d[1] = ax_y_val;
        end
      endcase
      held_d = (held_q & ~rel_m) | press_m;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= njm_pkg::ModeAnalog;
      active_q <= 1'b0;
      axis_q   <= '{default: njm_pkg::AxisMid};
      hat_q    <= njm_pkg::HatCenter;
      held_q   <= '0;
    end else if (s1_adv) begin
      mode_q   <= mode_d;
      active_q <= active_d;
      axis_q   <= axis_d;
      hat_q    <= hat_d;
      held_q   <= held_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Report outputs straight from the state
  // ---------------------------------------------------------------------------
  assign out_valid_o   = out_valid_q;
  assign axis_x_o      = axis_q[0];
  assign axis_y_o      = axis_q[1];
  assign axis_z_o      = axis_q[2];
  assign axis_zrot_o   = axis_q[3];
  assign hat_angle_o   = $signed(hat_q);
  assign button_mask_o = held_q;
  assign mode_now_o    = mode_q;
  assign active_now_o  = active_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // a stalled report must not move underneath the receiver
  a_report_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> ($stable(axis_q[0]) && $stable(axis_q[1]) &&
      $stable(axis_q[2]) && $stable(axis_q[3]) && $stable(hat_q) &&
      $stable(held_q) && $stable(mode_q) && $stable(active_q)))
    else $error("report state changed while stalled");

  // back pressure only with a poll waiting
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without a blocked poll");

  // an activate poll yields an active, cleared report
  a_activate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && poll_q.activate) |=> (out_valid_q && active_q && held_q == '0 &&
      hat_q == njm_pkg::HatCenter))
    else $error("activate poll did not clear the report");

  // every advanced poll produces a visible report next cycle
  a_adv_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_q)
    else $error("advanced poll lost its report");

endmodule

// File: dv/njm_report_checker.sv
`timescale 1ns / 1ps
// Report checker for the controller-to-joystick mapper: watches the poll, report and
// configuration ports, predicts every report and compares it field by field.
// Depends on njm_pkg for the poll type, mode codes, bit positions and register indexes.

module njm_report_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  njm_pkg::poll_t    poll_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [9:0]        axis_x_i,
  input  logic [9:0]        axis_y_i,
  input  logic [9:0]        axis_z_i,
  input  logic [9:0]        axis_zrot_i,
  input  logic signed [9:0] hat_angle_i,
  input  logic [9:0]        button_mask_i,
  input  logic [1:0]        mode_now_i,
  input  logic              active_now_i,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic [2:0]        paddr_i,
  input  logic [31:0]       pwdata_i,
  input  logic              pready_i,
  output int unsigned       fail_count_o,
  output int unsigned       pending_o
);

  localparam logic [3:0] DirsUp    = 4'(1 << njm_pkg::DirUp);
  localparam logic [3:0] DirsDown  = 4'(1 << njm_pkg::DirDown);
  localparam logic [3:0] DirsLeft  = 4'(1 << njm_pkg::DirLeft);
  localparam logic [3:0] DirsRight = 4'(1 << njm_pkg::DirRight);

  typedef struct packed {
    logic [9:0] axis_x;
    logic [9:0] axis_y;
    logic [9:0] axis_z;
    logic [9:0] axis_zrot;
    logic [9:0] hat;
    logic [9:0] buttons;
    logic [1:0] mode;
    logic       active;
  } report_t;

  // predicted mapper state
  logic [7:0] x_origin;
  logic [7:0] y_origin;
  logic [1:0] stick_mode;
  logic       is_active;
  logic [9:0] axis_reg [4];
  logic [9:0] hat_reg;
  logic [9:0] held;

  report_t     expected_reports[$];
  report_t     want;
  int unsigned mismatches;

  function automatic logic [9:0] scale_axis(logic [7:0] sample, logic [7:0] center,
                                            bit mirror);
    int v;
    v = 512 + 5 * (int'(sample) - int'(center));
    if (mirror) v = 1023 - v;
    if (v < 0) v = 0;
    else if (v > 1023) v = 1023;
    return 10'(v);
  endfunction

  function automatic logic [9:0] hat_angle_of(logic [3:0] dirs);
    case (dirs)
      DirsUp:               return 10'd0;
      DirsUp | DirsRight:   return 10'd45;
      DirsRight:            return 10'd90;
      DirsDown | DirsRight: return 10'd135;
      DirsDown:             return 10'd180;
      DirsDown | DirsLeft:  return 10'd225;
      DirsLeft:             return 10'd270;
      DirsUp | DirsLeft:    return 10'd315;
      default:              return njm_pkg::HatCenter;
    endcase
  endfunction

  function automatic void clear_report();
    for (int k = 0; k < 4; k++) axis_reg[k] = njm_pkg::AxisMid;
    hat_reg = njm_pkg::HatCenter;
    held    = '0;
  endfunction

  // press beats release when both edges arrive in one poll
  function automatic void set_button(logic pressed, logic released, int unsigned pos);
    if (pressed) held[pos] = 1'b1;
    else if (released) held[pos] = 1'b0;
  endfunction

  function automatic report_t map_poll(njm_pkg::poll_t p);
    int unsigned c_pos;
    int unsigned z_pos;
    c_pos = njm_pkg::BtnA;
    z_pos = njm_pkg::BtnB;
    if (p.activate) begin
      is_active = 1'b1;
      clear_report();
    end else if (p.tilted_up) begin
      clear_report();
      if (p.c_pressed) is_active = 1'b0;
      // later checks win: right has the last word
      if (p.dir_pressed[njm_pkg::DirUp])    stick_mode = njm_pkg::ModeAnalog;
      if (p.dir_pressed[njm_pkg::DirDown])  stick_mode = njm_pkg::ModeDigital;
      if (p.dir_pressed[njm_pkg::DirLeft])  stick_mode = njm_pkg::ModeFpsLeft;
      if (p.dir_pressed[njm_pkg::DirRight]) stick_mode = njm_pkg::ModeFpsRight;
    end else if (p.side_tilted) begin
      set_button(p.z_pressed, p.z_released, njm_pkg::BtnStart);
      set_button(p.c_pressed, p.c_released, njm_pkg::BtnSelect);
      set_button(p.dir_pressed[njm_pkg::DirDown], p.dir_released[njm_pkg::DirDown],
                 njm_pkg::BtnB);
      set_button(p.dir_pressed[njm_pkg::DirRight], p.dir_released[njm_pkg::DirRight],
                 njm_pkg::BtnA);
      set_button(p.dir_pressed[njm_pkg::DirLeft], p.dir_released[njm_pkg::DirLeft],
                 njm_pkg::BtnY);
      set_button(p.dir_pressed[njm_pkg::DirUp], p.dir_released[njm_pkg::DirUp],
                 njm_pkg::BtnX);
    end else begin
      if (stick_mode == njm_pkg::ModeFpsLeft) begin
        z_pos = njm_pkg::BtnLt;
        c_pos = njm_pkg::BtnLb;
      end
      if (stick_mode == njm_pkg::ModeFpsRight) begin
        z_pos = njm_pkg::BtnRt;
        c_pos = njm_pkg::BtnRb;
      end
      set_button(p.z_pressed, p.z_released, z_pos);
      set_button(p.c_pressed, p.c_released, c_pos);
      if (stick_mode == njm_pkg::ModeDigital) begin
        hat_reg = hat_angle_of(p.digital_dir);
      end else if (stick_mode == njm_pkg::ModeFpsRight) begin
        axis_reg[2] = scale_axis(p.stick_y, y_origin, 1'b1);
        axis_reg[3] = scale_axis(p.stick_x, x_origin, 1'b0);
      end else begin
        axis_reg[0] = scale_axis(p.stick_x, x_origin, 1'b0);
        axis_reg[1] = scale_axis(p.stick_y, y_origin, 1'b1);
      end
    end
    return '{axis_reg[0], axis_reg[1], axis_reg[2], axis_reg[3], hat_reg, held,
             stick_mode, is_active};
  endfunction

  function automatic int unsigned field_mismatch(string name, logic signed [31:0] exp_val,
                                                 logic signed [31:0] got_val);
    if (got_val === exp_val) return 0;
    $error("%s: expected %0d, got %0d", name, exp_val, got_val);
    return 1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_origin   = 8'd128;
      y_origin   = 8'd128;
      stick_mode = njm_pkg::ModeAnalog;
      is_active  = 1'b0;
      clear_report();
      expected_reports.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      mismatches = 0;
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (paddr_i[2] == njm_pkg::RegCenterY) y_origin = pwdata_i[7:0];
        else x_origin = pwdata_i[7:0];
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_reports.size() == 0) begin
          $error("report transaction with no poll waiting");
          mismatches = 1;
        end else begin
          want = expected_reports.pop_front();
          mismatches += field_mismatch("axis_x", want.axis_x, axis_x_i);
          mismatches += field_mismatch("axis_y", want.axis_y, axis_y_i);
          mismatches += field_mismatch("axis_z", want.axis_z, axis_z_i);
          mismatches += field_mismatch("axis_zrot", want.axis_zrot, axis_zrot_i);
          mismatches += field_mismatch("hat_angle", $signed(want.hat), hat_angle_i);
          mismatches += field_mismatch("button_mask", want.buttons, button_mask_i);
          mismatches += field_mismatch("mode_now", want.mode, mode_now_i);
          mismatches += field_mismatch("active_now", want.active, active_now_i);
        end
      end
      if (in_valid_i && !in_stall_i) expected_reports.push_back(map_poll(poll_i));
      fail_count_o <= fail_count_o + mismatches;
      pending_o    <= expected_reports.size();
    end
  end

endmodule

// File: dv/nunchuck_to_joystick_mapper_unit_tb.sv
`timescale 1ns / 1ps
// Testbench top for the controller-to-joystick mapper: clock, reset, poll and report
// stimulus, center register writes and the verdict. Depends on njm_pkg, the mapper
// RTL and njm_report_checker, which does all prediction and comparison.

module nunchuck_to_joystick_mapper_unit_tb;

  localparam int unsigned HalfPeriod      = 10;
  localparam int unsigned CycleLimit      = 400000;
  localparam int unsigned HoldCycles      = 120;
  localparam int unsigned ItemsPerSetting = 270;
  localparam int unsigned TailCycles      = 10;

  localparam logic [3:0] DirsUp    = 4'(1 << njm_pkg::DirUp);
  localparam logic [3:0] DirsDown  = 4'(1 << njm_pkg::DirDown);
  localparam logic [3:0] DirsLeft  = 4'(1 << njm_pkg::DirLeft);
  localparam logic [3:0] DirsRight = 4'(1 << njm_pkg::DirRight);

  logic           clk_i       = 1'b0;
  logic           rst_ni      = 1'b0;
  logic           in_valid_i  = 1'b0;
  logic           out_stall_i = 1'b0;
  njm_pkg::poll_t poll_q      = '0;
  logic           psel        = 1'b0;
  logic           penable     = 1'b0;
  logic           pwrite      = 1'b0;
  logic [2:0]     paddr       = '0;
  logic [31:0]    pwdata      = '0;

  logic              in_stall_o;
  logic              out_valid_o;
  logic [9:0]        axis_x_o;
  logic [9:0]        axis_y_o;
  logic [9:0]        axis_z_o;
  logic [9:0]        axis_zrot_o;
  logic signed [9:0] hat_angle_o;
  logic [9:0]        button_mask_o;
  logic [1:0]        mode_now_o;
  logic              active_now_o;
  logic [31:0]       prdata;
  logic              pready;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count = 0;

  // handshake between the stimulus and the receiver for the long hold-off
  bit hold_req    = 1'b0;
  bit hold_active = 1'b0;

  // centers currently programmed, so sticks can be aimed around them
  logic [7:0] cur_cx = 8'd128;
  logic [7:0] cur_cy = 8'd128;

  always #(HalfPeriod) clk_i = ~clk_i;

  nunchuck_to_joystick_mapper_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .activate_i    (poll_q.activate),
    .tilted_up_i   (poll_q.tilted_up),
    .side_tilted_i (poll_q.side_tilted),
    .c_pressed_i   (poll_q.c_pressed),
    .c_released_i  (poll_q.c_released),
    .z_pressed_i   (poll_q.z_pressed),
    .z_released_i  (poll_q.z_released),
    .dir_pressed_i (poll_q.dir_pressed),
    .dir_released_i(poll_q.dir_released),
    .digital_dir_i (poll_q.digital_dir),
    .stick_x_i     (poll_q.stick_x),
    .stick_y_i     (poll_q.stick_y),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .axis_x_o      (axis_x_o),
    .axis_y_o      (axis_y_o),
    .axis_z_o      (axis_z_o),
    .axis_zrot_o   (axis_zrot_o),
    .hat_angle_o   (hat_angle_o),
    .button_mask_o (button_mask_o),
    .mode_now_o    (mode_now_o),
    .active_now_o  (active_now_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  njm_report_checker report_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .poll_i       (poll_q),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .axis_x_i     (axis_x_o),
    .axis_y_i     (axis_y_o),
    .axis_z_i     (axis_z_o),
    .axis_zrot_i  (axis_zrot_o),
    .hat_angle_i  (hat_angle_o),
    .button_mask_i(button_mask_o),
    .mode_now_i   (mode_now_o),
    .active_now_i (active_now_o),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .pready_i     (pready),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Watchdog: abort a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver: stall in segments of random style and length; on request, hold off
  // for a long fixed stretch so the mapper fills up and stalls its poll input.
  initial begin
    int unsigned style;
    int unsigned span;
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_stall_i <= 1'b1;
        hold_active = 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        hold_active = 1'b0;
        hold_req    = 1'b0;
      end else begin
        style = $urandom_range(0, 3);
        span  = $urandom_range(4, 40);
        repeat (span) begin
          case (style)
            0:       out_stall_i <= 1'b0;
            1:       out_stall_i <= ($urandom_range(0, 1) == 0);
            2:       out_stall_i <= ($urandom_range(0, 4) != 0);
            default: out_stall_i <= ($urandom_range(0, 4) == 0);
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  // All stimulus tasks are entered at a rising edge and return at one.

  // Offer one poll and hold it until the transaction completes.
  task automatic offer_poll(input njm_pkg::poll_t p);
    in_valid_i <= 1'b1;
    poll_q     <= p;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic idle_cycles(input int unsigned n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Drop valid and wait until every predicted report has been taken.
  task automatic drain_reports();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Setup cycle, then access cycle; the write lands when pready is seen high.
  // Go idle after the access so back-to-back writes get a fresh setup.
  task automatic write_reg(input logic reg_idx, input logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= {24'($urandom), value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Reprogram both centers; only ever done with nothing in flight.
  task automatic set_centers(input logic [7:0] cx, input logic [7:0] cy);
    drain_reports();
    write_reg(njm_pkg::RegCenterX, cx);
    write_reg(njm_pkg::RegCenterY, cy);
    cur_cx = cx;
    cur_cy = cy;
  endtask

  // Mostly within 120 of the center (kept to the byte range), sometimes anywhere.
  function automatic logic [7:0] stick_sample(input logic [7:0] center);
    int v;
    if ($urandom_range(0, 3) == 0) return 8'($urandom);
    v = int'(center) + int'($urandom_range(0, 240)) - 120;
    if (v < 0) v = 0;
    else if (v > 255) v = 255;
    return 8'(v);
  endfunction

  // Mix of activations, mode selects, button-mode polls and plain stick polls.
  function automatic njm_pkg::poll_t random_poll();
    njm_pkg::poll_t p;
    int unsigned    kind;
    kind          = $urandom_range(0, 99);
    p.activate    = (kind < 4);
    p.tilted_up   = (kind < 4) ? 1'($urandom) : (kind < 14);
    p.side_tilted = (kind < 14) ? 1'($urandom) : (kind < 30);
    p.c_pressed   = ($urandom_range(0, 2) == 0);
    p.c_released  = ($urandom_range(0, 2) == 0);
    p.z_pressed   = ($urandom_range(0, 2) == 0);
    p.z_released  = ($urandom_range(0, 2) == 0);
    // in select mode prefer a single direction so every stick mode gets picked
    if (p.tilted_up && $urandom_range(0, 3) != 0) p.dir_pressed = 4'(1 << $urandom_range(0, 3));
    else p.dir_pressed = 4'($urandom);
    p.dir_released = ($urandom_range(0, 1) == 0) ? 4'($urandom) : 4'h0;
    p.digital_dir  = 4'($urandom);
    p.stick_x      = stick_sample(cur_cx);
    p.stick_y      = stick_sample(cur_cy);
    return p;
  endfunction

  // Random polls sent in bursts, with idle gaps between most bursts.
  task automatic run_random(input int unsigned count);
    int unsigned burst_left;
    burst_left = 0;
    repeat (count) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 7));
      end
      burst_left--;
      offer_poll(random_poll());
    end
  endtask

  initial begin
    njm_pkg::poll_t p;
    logic [7:0]     cx_list [6];
    logic [7:0]     cy_list [6];

    cx_list = '{8'd128, 8'd0, 8'd255, 8'd0, 8'd255, 8'($urandom)};
    cy_list = '{8'd128, 8'd255, 8'd0, 8'd0, 8'd255, 8'($urandom)};

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed polls at the reset centers.
    // Activate with every other field set: the rest must be ignored.
    p = '1;
    offer_poll(p);
    // Analog: stick at its minimum on both axes, clamping both axes.
    p = '0;
    offer_poll(p);
    // Press and release together: press wins.
    p = '0; p.stick_x = 8'hFF; p.stick_y = 8'hFF;
    p.c_pressed = 1'b1; p.c_released = 1'b1; p.z_pressed = 1'b1;
    offer_poll(p);
    p = '0; p.stick_x = 8'd128; p.stick_y = 8'd128; p.c_released = 1'b1; p.z_released = 1'b1;
    offer_poll(p);
    // Both tilts: tilted up wins; all directions pressed picks fps right; C drops active.
    p = '0; p.tilted_up = 1'b1; p.side_tilted = 1'b1; p.dir_pressed = 4'hF; p.c_pressed = 1'b1;
    offer_poll(p);
    // Inactive polls still map; fps right drives Z and Z rotation.
    p = '0; p.stick_x = 8'd0; p.stick_y = 8'd255; p.z_pressed = 1'b1; p.c_pressed = 1'b1;
    offer_poll(p);
    p = '0; p.stick_x = 8'd200; p.stick_y = 8'd60; p.z_released = 1'b1;
    offer_poll(p);
    // Select fps left.
    p = '0; p.tilted_up = 1'b1; p.dir_pressed = DirsLeft;
    offer_poll(p);
    p = '0; p.stick_x = 8'd255; p.stick_y = 8'd0; p.z_pressed = 1'b1; p.c_pressed = 1'b1;
    offer_poll(p);
    // Up and down together: down is checked later, so digital.
    p = '0; p.tilted_up = 1'b1; p.dir_pressed = DirsUp | DirsDown;
    offer_poll(p);
    p = '0; p.digital_dir = DirsUp | DirsRight;
    offer_poll(p);
    p = '0; p.digital_dir = DirsDown | DirsLeft; p.z_pressed = 1'b1;
    offer_poll(p);
    // Direction sets that are no hat position center the hat.
    p = '0; p.digital_dir = DirsUp | DirsDown;
    offer_poll(p);
    p = '0; p.digital_dir = 4'hF; p.c_pressed = 1'b1;
    offer_poll(p);
    p = '0; p.activate = 1'b1;
    offer_poll(p);
    // Button mode: every direction and both buttons pressed, then released, with down pressed again so B stays held.
    p = '0; p.side_tilted = 1'b1; p.dir_pressed = 4'hF; p.z_pressed = 1'b1; p.c_pressed = 1'b1;
    offer_poll(p);
    p = '0; p.side_tilted = 1'b1; p.dir_released = 4'hF; p.dir_pressed = DirsDown;
    p.z_released = 1'b1; p.c_released = 1'b1;
    offer_poll(p);
    // Back to analog; the direction set must not matter here.
    p = '0; p.tilted_up = 1'b1; p.dir_pressed = DirsUp;
    offer_poll(p);
    p = '0; p.stick_x = 8'd1; p.stick_y = 8'd254; p.digital_dir = 4'hF;
    offer_poll(p);

    // Random phases, one per center setting, extremes included.
    for (int phase = 0; phase < 6; phase++) begin
      set_centers(cx_list[phase], cy_list[phase]);
      if (phase == 1) begin
        // Stop offering, start the long hold-off, then push polls into a full pipe.
        in_valid_i <= 1'b0;
        hold_req = 1'b1;
        do @(posedge clk_i); while (!hold_active);
        repeat (24) offer_poll(random_poll());
      end
      run_random(ItemsPerSetting);
    end

    drain_reports();
    repeat (TailCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/njm_pkg.sv
rtl/nunchuck_to_joystick_mapper_unit.sv
dv/njm_report_checker.sv
dv/nunchuck_to_joystick_mapper_unit_tb.sv
